// File: hw/rtl/ppur_pkg.sv
// Shared types, constants and sizes for the register and VRAM port unit.
`default_nettype none

package ppur_pkg;

    // Memory sizes and their address widths
    localparam int NAME_RAM_BYTES    = 4096;
    localparam int NT_AW             = $clog2(NAME_RAM_BYTES);
    localparam int PATTERN_RAM_BYTES = 8192;
    localparam int PAT_AW            = $clog2(PATTERN_RAM_BYTES);
    localparam int OAM_BYTES         = 256;
    localparam int OAM_AW            = $clog2(OAM_BYTES);
    localparam int PAL_BYTES         = 32;
    localparam int PAL_AW            = $clog2(PAL_BYTES);

    // Configuration port
    localparam int  APB_AW         = 3;
    localparam logic CFG_IDX_MIRROR = 1'b0;

    typedef enum logic [2:0] {
        MIR_HORZ      = 3'd0,
        MIR_VERT      = 3'd1,
        MIR_SINGLE_LO = 3'd2,
        MIR_SINGLE_HI = 3'd3,
        MIR_FOUR      = 3'd4
    } t_mirror;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_WRITE     = 2'd1,
        OP_VBLANK    = 2'd2,
        OP_PRERENDER = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_CTRL    = 3'd0,
        REG_MASK    = 3'd1,
        REG_STATUS  = 3'd2,
        REG_OAMADDR = 3'd3,
        REG_OAMDATA = 3'd4,
        REG_SCROLL  = 3'd5,
        REG_ADDR    = 3'd6,
        REG_DATA    = 3'd7
    } t_reg;

    typedef enum logic [3:0] {
        CMD_ZERO,
        CMD_RD_STATUS,
        CMD_RD_OAM,
        CMD_RD_DATA,
        CMD_WR_CTRL,
        CMD_WR_OAMADDR,
        CMD_WR_OAMDATA,
        CMD_WR_SCROLL,
        CMD_WR_ADDR,
        CMD_WR_DATA,
        CMD_VBLANK,
        CMD_PRERENDER
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WAIT
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/ppu_register_and_vram_port_unit.sv
// Top level of the register and VRAM port unit: config port, front and back ends.
`default_nettype none

// CPU-side register port of a tile video processor. Each input word is a register read,
// a register write, a vblank start or a pre-render clear; each yields one output word
// carrying the read byte and an NMI flag. Words pass through a two-entry command queue
// to an execute stage: data (VRAM) and sprite-data reads pass through a wait state there,
// because they wait on a synchronous RAM read; every other word is executed without it. The
// output register lets the next word be taken while a result waits. After reset the
// execute stage zeroes pattern, nametable, sprite and palette RAM in one pass, during
// which s_axis_tready stays low. The mirroring mode sits at byte address 0 of the APB
// port (0 horizontal, 1 vertical, 2 single lower, 3 single upper, 4 to 7 four-screen);
// change it only while the block is idle.
module ppu_register_and_vram_port_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,  // reg_index, write_data
    input  wire logic [1:0]                    s_axis_tuser,  // operation
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [15:0]                        m_axis_tdata,  // read_data, nmi_request
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppur_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [2:0]          r_mirror;
    ppur_pkg::t_cmd_head head;
    logic                pop;
    logic                clearing;
    logic [7:0]          out_data;
    logic                out_nmi;
    logic                w_sel_mirror;

    assign pready       = 1'b1;
    assign w_sel_mirror = (paddr[2] == ppur_pkg::CFG_IDX_MIRROR);
    assign prdata       = w_sel_mirror ? {29'd0, r_mirror} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror <= 3'd0;
        end else if (psel && penable && pwrite && pready && w_sel_mirror) begin
            r_mirror <= pwdata[2:0];
        end
    end

    ppur_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_clearing    (clearing),
        .i_pop         (pop),
        .o_head        (head)
    );

    ppur_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mirror    (r_mirror),
        .i_head      (head),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (out_data),
        .o_out_nmi   (out_nmi),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, out_nmi, out_data};

endmodule

`default_nettype wire

// File: hw/rtl/ppur_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module ppur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/ppur_front.sv
// Front end: accepts input words, classifies them and queues commands.
`default_nettype none

module ppur_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,
    input  wire logic [1:0]           s_axis_tuser,
    input  wire logic                 i_clearing,
    input  wire logic                 i_pop,
    output ppur_pkg::t_cmd_head       o_head
);

    logic [1:0]          op;
    logic [2:0]          reg_idx;
    ppur_pkg::t_cmd      w_cmd;
    ppur_pkg::t_cmd      r_q [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;
    logic                w_push;

    assign op      = s_axis_tuser;
    assign reg_idx = s_axis_tdata[2:0];

    always_comb begin
        w_cmd.data = s_axis_tdata[10:3];
        w_cmd.kind = ppur_pkg::CMD_ZERO;
        case (op)
            ppur_pkg::OP_READ: begin
                case (reg_idx)
                    ppur_pkg::REG_STATUS:  w_cmd.kind = ppur_pkg::CMD_RD_STATUS;
                    ppur_pkg::REG_OAMDATA: w_cmd.kind = ppur_pkg::CMD_RD_OAM;
                    ppur_pkg::REG_DATA:    w_cmd.kind = ppur_pkg::CMD_RD_DATA;
                    default:               w_cmd.kind = ppur_pkg::CMD_ZERO;
                endcase
            end
            ppur_pkg::OP_WRITE: begin
                case (reg_idx)
                    ppur_pkg::REG_CTRL:    w_cmd.kind = ppur_pkg::CMD_WR_CTRL;
                    ppur_pkg::REG_OAMADDR: w_cmd.kind = ppur_pkg::CMD_WR_OAMADDR;
                    ppur_pkg::REG_OAMDATA: w_cmd.kind = ppur_pkg::CMD_WR_OAMDATA;
                    ppur_pkg::REG_SCROLL:  w_cmd.kind = ppur_pkg::CMD_WR_SCROLL;
                    ppur_pkg::REG_ADDR:    w_cmd.kind = ppur_pkg::CMD_WR_ADDR;
                    ppur_pkg::REG_DATA:    w_cmd.kind = ppur_pkg::CMD_WR_DATA;
                    // mask only steers rendering; status is read-only
                    default:               w_cmd.kind = ppur_pkg::CMD_ZERO;
                endcase
            end
            ppur_pkg::OP_VBLANK:    w_cmd.kind = ppur_pkg::CMD_VBLANK;
            ppur_pkg::OP_PRERENDER: w_cmd.kind = ppur_pkg::CMD_PRERENDER;
            default:                w_cmd.kind = ppur_pkg::CMD_ZERO;
        endcase
    end

    // Hold off input while the memories are being cleared
    assign s_axis_tready = (r_count != 2'd2) && !i_clearing;
    assign w_push        = s_axis_tvalid && s_axis_tready;

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.cmd   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/ppur_back.sv
// Back end: executes queued commands against registers and video memories.
`default_nettype none

module ppur_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [2:0]           i_mirror,
    input  wire ppur_pkg::t_cmd_head  i_head,
    output logic                      o_pop,
    output logic                      o_clearing,
    output logic                      o_out_valid,
    output logic [7:0]                o_out_data,
    output logic                      o_out_nmi,
    input  wire logic                 i_out_ready
);

    ppur_pkg::t_state r_state, n_state;
    logic [ppur_pkg::PAT_AW-1:0] r_clr_cnt, n_clr_cnt;
    logic [14:0] r_v, n_v;
    logic [14:0] r_t, n_t;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_buf, n_buf;
    // status vblank flag and vblank-occurred latch always move together
    logic        r_vblank, n_vblank;
    logic        r_nmi_en, n_nmi_en;
    logic        r_inc32, n_inc32;
    logic [7:0]  r_oam_addr, n_oam_addr;
    logic        r_wait_data, n_wait_data;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_data, n_out_data;
    logic        r_out_nmi, n_out_nmi;

    logic        w_clr;
    logic        w_go;
    logic        w_slot_free;
    logic        w_is_pat;
    logic        w_is_pal;
    logic [11:0] w_nt_full;
    logic [ppur_pkg::PAL_AW-1:0] w_pal_idx;
    logic [14:0] w_v_next;
    logic [7:0]  w_vram_rd;
    ppur_pkg::t_cmd_kind w_kind;
    logic [7:0]  w_d;

    logic        oam_we, pat_we, nt_we, pal_we;
    logic [ppur_pkg::OAM_AW-1:0] oam_addr;
    logic [ppur_pkg::PAT_AW-1:0] pat_addr;
    logic [ppur_pkg::NT_AW-1:0]  nt_addr;
    logic [ppur_pkg::PAL_AW-1:0] pal_addr;
    logic [7:0]  wdata;
    logic [7:0]  oam_rdata, pat_rdata, nt_rdata, pal_rdata;

    assign w_kind      = i_head.cmd.kind;
    assign w_d         = i_head.cmd.data;
    assign w_clr       = (r_state == ppur_pkg::ST_CLEAR);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_go        = (r_state == ppur_pkg::ST_IDLE) && i_head.valid && w_slot_free;
    assign o_pop       = w_go;
    assign o_clearing  = w_clr;

    assign w_is_pat = !r_v[13];
    assign w_is_pal = (r_v[13:8] == 6'h3F);
    assign w_v_next = r_v + (r_inc32 ? 15'd32 : 15'd1);

    // Fold the nametable address by mirroring mode
    always_comb begin
        case (i_mirror)
            ppur_pkg::MIR_HORZ:      w_nt_full = {1'b0, r_v[11], r_v[9:0]};
            ppur_pkg::MIR_VERT:      w_nt_full = {1'b0, r_v[10:0]};
            ppur_pkg::MIR_SINGLE_LO: w_nt_full = {2'b00, r_v[9:0]};
            ppur_pkg::MIR_SINGLE_HI: w_nt_full = {2'b01, r_v[9:0]};
            default:                 w_nt_full = r_v[11:0];
        endcase
    end

    // Backdrop entries of the sprite palettes alias the background ones
    assign w_pal_idx = {r_v[4] & (r_v[1:0] != 2'b00), r_v[3:0]};

    assign oam_addr = w_clr ? r_clr_cnt[ppur_pkg::OAM_AW-1:0] : r_oam_addr;
    assign pat_addr = w_clr ? r_clr_cnt : r_v[ppur_pkg::PAT_AW-1:0];
    assign nt_addr  = w_clr ? r_clr_cnt[ppur_pkg::NT_AW-1:0]
                            : w_nt_full[ppur_pkg::NT_AW-1:0];
    assign pal_addr = w_clr ? r_clr_cnt[ppur_pkg::PAL_AW-1:0] : w_pal_idx;
    assign wdata    = w_clr ? 8'h00 : w_d;

    assign oam_we = w_clr || (w_go && (w_kind == ppur_pkg::CMD_WR_OAMDATA));
    assign pat_we = w_clr || (w_go && (w_kind == ppur_pkg::CMD_WR_DATA) && w_is_pat);
    assign nt_we  = w_clr || (w_go && (w_kind == ppur_pkg::CMD_WR_DATA)
                              && !w_is_pat && !w_is_pal);
    assign pal_we = w_clr || (w_go && (w_kind == ppur_pkg::CMD_WR_DATA) && w_is_pal);

    ppur_ram #(.WIDTH(8), .DEPTH(ppur_pkg::OAM_BYTES)) u_oam_ram (
        .i_clk   (i_clk),
        .i_we    (oam_we),
        .i_addr  (oam_addr),
        .i_wdata (wdata),
        .o_rdata (oam_rdata)
    );

    ppur_ram #(.WIDTH(8), .DEPTH(ppur_pkg::PATTERN_RAM_BYTES)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_addr  (pat_addr),
        .i_wdata (wdata),
        .o_rdata (pat_rdata)
    );

    ppur_ram #(.WIDTH(8), .DEPTH(ppur_pkg::NAME_RAM_BYTES)) u_nt_ram (
        .i_clk   (i_clk),
        .i_we    (nt_we),
        .i_addr  (nt_addr),
        .i_wdata (wdata),
        .o_rdata (nt_rdata)
    );

    ppur_ram #(.WIDTH(8), .DEPTH(ppur_pkg::PAL_BYTES)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_addr  (pal_addr),
        .i_wdata (wdata),
        .o_rdata (pal_rdata)
    );

    // v does not move between issuing the read and using its data
    assign w_vram_rd = w_is_pat ? pat_rdata : (w_is_pal ? pal_rdata : nt_rdata);

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_v         = r_v;
        n_t         = r_t;
        n_toggle    = r_toggle;
        n_buf       = r_buf;
        n_vblank    = r_vblank;
        n_nmi_en    = r_nmi_en;
        n_inc32     = r_inc32;
        n_oam_addr  = r_oam_addr;
        n_wait_data = r_wait_data;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_out_nmi   = r_out_nmi;

        case (r_state)
            ppur_pkg::ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + ppur_pkg::PAT_AW'(1);
                if (&r_clr_cnt) begin
                    n_state = ppur_pkg::ST_IDLE;
                end
            end
            ppur_pkg::ST_IDLE: begin
                if (w_go) begin
                    n_out_valid = 1'b1;
                    n_out_data  = 8'h00;
                    n_out_nmi   = 1'b0;
                    case (w_kind)
                        ppur_pkg::CMD_RD_STATUS: begin
                            n_out_data = {r_vblank, 2'b00, r_buf[4:0]};
                            n_vblank   = 1'b0;
                            n_toggle   = 1'b0;
                        end
                        ppur_pkg::CMD_RD_OAM: begin
                            n_out_valid = 1'b0;
                            n_wait_data = 1'b0;
                            n_state     = ppur_pkg::ST_WAIT;
                        end
                        ppur_pkg::CMD_RD_DATA: begin
                            n_out_valid = 1'b0;
                            n_wait_data = 1'b1;
                            n_state     = ppur_pkg::ST_WAIT;
                        end
                        ppur_pkg::CMD_WR_CTRL: begin
                            n_inc32      = w_d[2];
                            n_nmi_en     = w_d[7];
                            n_t[11:10]   = w_d[1:0];
                            n_out_nmi    = w_d[7] && !r_nmi_en && r_vblank;
                        end
                        ppur_pkg::CMD_WR_OAMADDR: begin
                            n_oam_addr = w_d;
                        end
                        ppur_pkg::CMD_WR_OAMDATA: begin
                            n_oam_addr = r_oam_addr + 8'd1;
                        end
                        ppur_pkg::CMD_WR_SCROLL: begin
                            // fine x only feeds rendering
                            if (!r_toggle) begin
                                n_t[4:0] = w_d[7:3];
                            end else begin
                                n_t[14:12] = w_d[2:0];
                                n_t[9:5]   = w_d[7:3];
                            end
                            n_toggle = ~r_toggle;
                        end
                        ppur_pkg::CMD_WR_ADDR: begin
                            if (!r_toggle) begin
                                n_t[14:8] = {1'b0, w_d[5:0]};
                            end else begin
                                n_t[7:0] = w_d;
                                n_v      = {r_t[14:8], w_d};
                            end
                            n_toggle = ~r_toggle;
                        end
                        ppur_pkg::CMD_WR_DATA: begin
                            n_v = w_v_next;
                        end
                        ppur_pkg::CMD_VBLANK: begin
                            n_vblank  = 1'b1;
                            n_out_nmi = r_nmi_en;
                        end
                        ppur_pkg::CMD_PRERENDER: begin
                            n_vblank = 1'b0;
                        end
                        default: begin
                            n_out_data = 8'h00;
                        end
                    endcase
                end
            end
            ppur_pkg::ST_WAIT: begin
                // output slot was freed when the read was issued
                n_out_valid = 1'b1;
                n_out_nmi   = 1'b0;
                n_state     = ppur_pkg::ST_IDLE;
                if (r_wait_data) begin
                    n_buf      = w_vram_rd;
                    n_out_data = w_is_pal ? w_vram_rd : r_buf;
                    n_v        = w_v_next;
                end else begin
                    n_out_data = oam_rdata;
                end
            end
            default: begin
                n_state = ppur_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppur_pkg::ST_CLEAR;
            r_clr_cnt   <= '0;
            r_v         <= '0;
            r_t         <= '0;
            r_toggle    <= 1'b0;
            r_buf       <= 8'h00;
            r_vblank    <= 1'b0;
            r_nmi_en    <= 1'b0;
            r_inc32     <= 1'b0;
            r_oam_addr  <= 8'h00;
            r_wait_data <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_v         <= n_v;
            r_t         <= n_t;
            r_toggle    <= n_toggle;
            r_buf       <= n_buf;
            r_vblank    <= n_vblank;
            r_nmi_en    <= n_nmi_en;
            r_inc32     <= n_inc32;
            r_oam_addr  <= n_oam_addr;
            r_wait_data <= n_wait_data;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_nmi  <= n_out_nmi;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_nmi   = r_out_nmi;

endmodule

`default_nettype wire

// File: hw/rtl/ppur_checker.sv
// Port-level checks for the register and VRAM port unit, bound to the top level.
`default_nettype none

module ppur_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [15:0]                 m_axis_tdata,
    input wire logic [31:0]                 prdata,
    input wire logic                        pready
);

    // A stalled result word holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Pad bits above the NMI flag stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'd0))
        else $error("result pad bits set");

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");

    // Only the three mirroring bits read back
    a_cfg_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && (prdata[31:3] == 29'd0))
        else $error("config read back out of range");

endmodule

bind ppu_register_and_vram_port_unit ppur_checker u_ppur_checker (.*);

`default_nettype wire
